>>> hw/rtl/ucbi_pkg.sv
package ucbi_pkg;

   // Code points that the break rule and the decoder look at.
   localparam logic [20:0] CP_ZWSP      = 21'h00200B;
   localparam logic [20:0] CP_LENT_OPEN = 21'h003010;
   localparam logic [20:0] CP_LENT_SHUT = 21'h003011;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
   localparam logic [20:0] CP_MIN_2B    = 21'h000080;
   localparam logic [20:0] CP_MIN_3B    = 21'h000800;
   localparam logic [20:0] CP_MIN_4B    = 21'h010000;

   // The encoded form of U+200B, sent ahead of a character when a break goes in.
   localparam logic [7:0] ZWSP_BYTE0 = 8'hE2;
   localparam logic [7:0] ZWSP_BYTE1 = 8'h80;
   localparam logic [7:0] ZWSP_BYTE2 = 8'h8B;

   // One unit of work handed from the decoder to the serializer.
   typedef struct packed {
      logic            err;       // single error result
      logic            brk;       // three break bytes go first
      logic [1:0]      len_m1;    // character length minus one
      logic [3:0][7:0] bytes;     // encoded character, byte 0 first
      logic            str_end;   // the causing byte closed its string
   } job_type;

   function automatic logic is_cjk(input logic [20:0] c);
      return (c >= 21'h002E80 && c <= 21'h00A4CF) || (c >= 21'h00AC00 && c <= 21'h00D7AF) ||
             (c >= 21'h00F900 && c <= 21'h00FAFF) || (c >= 21'h00FF00 && c <= 21'h00FFEF) ||
             (c >= 21'h020000 && c <= 21'h03134F);
   endfunction

   function automatic logic is_gap(input logic [20:0] c);
      return c == 21'h20 || c == 21'h0A || c == 21'h0D || c == 21'h09 ||
             c == 21'hA0 || c == CP_ZWSP;
   endfunction

   function automatic logic is_open(input logic [20:0] c);
      return c == CP_LENT_OPEN || c == 21'hFF08 || c == 21'h300C || c == 21'h300E ||
             c == 21'h300A || c == 21'h3008 || c == 21'h2018 || c == 21'h201C;
   endfunction

   function automatic logic is_close(input logic [20:0] c);
      return c == CP_LENT_SHUT || c == 21'hFF09 || c == 21'h300D || c == 21'h300F ||
             c == 21'h300B || c == 21'h3009 || c == 21'h2019 || c == 21'h201D ||
             c == 21'h3001 || c == 21'h3002 || c == 21'hFF0C || c == 21'hFF1A ||
             c == 21'hFF1B || c == 21'hFF01 || c == 21'hFF1F;
   endfunction

endpackage

>>> hw/rtl/ucbi_front.sv
module ucbi_front
   import ucbi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_end,
   input  logic        queue_full,
   output logic        push,
   output job_type     push_job
);

   logic [2:0]      exp_len_ff, exp_len_in;
   logic [2:0]      seen_len_ff, seen_len_in;
   logic [20:0]     code_ff, code_in;
   logic [3:0][7:0] rune_ff, rune_in;
   logic            prev_nz_ff, prev_nz_in;
   logic            prev_cjk_ff, prev_cjk_in;
   logic            prev_gap_ff, prev_gap_in;
   logic            prev_open_ff, prev_open_in;
   logic            brackets_ff, brackets_in;
   logic            discard_ff, discard_in;

   logic            accept;
   logic [2:0]      lead_len;
   logic [20:0]     lead_code;
   logic [20:0]     cont_code;
   logic [20:0]     cur_code;
   logic [2:0]      cur_len;
   logic [2:0]      seen_next;
   logic [3:0][7:0] char_bytes;
   logic            do_fail;
   logic            do_finish;
   logic            bad_code;
   logic            want_break;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Lead byte decode: length and payload bits, length 0 marks a bad lead.
   always_comb begin
      if (req_in_byte[7] == 1'b0) begin
         lead_len  = 3'd1;
         lead_code = {14'd0, req_in_byte[6:0]};
      end else if (req_in_byte[7:5] == 3'b110) begin
         lead_len  = 3'd2;
         lead_code = {16'd0, req_in_byte[4:0]};
      end else if (req_in_byte[7:4] == 4'b1110) begin
         lead_len  = 3'd3;
         lead_code = {17'd0, req_in_byte[3:0]};
      end else if (req_in_byte[7:3] == 5'b11110) begin
         lead_len  = 3'd4;
         lead_code = {18'd0, req_in_byte[2:0]};
      end else begin
         lead_len  = 3'd0;
         lead_code = 21'd0;
      end
   end

   assign cont_code = {code_ff[14:0], req_in_byte[5:0]};
   assign cur_code  = (exp_len_ff == 3'd0) ? lead_code : cont_code;
   assign cur_len   = (exp_len_ff == 3'd0) ? lead_len : exp_len_ff;
   assign seen_next = 3'(seen_len_ff + 3'd1);

   // The character so far with the current beat dropped in at its slot.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         char_bytes[k] = (seen_len_ff[1:0] == 2'(k)) ? req_in_byte : rune_ff[k];
      end
   end

   // Overlong forms, surrogates and values past the last plane.
   assign bad_code = (cur_len == 3'd2 && cur_code < CP_MIN_2B) ||
                     (cur_len == 3'd3 && cur_code < CP_MIN_3B) ||
                     (cur_len == 3'd4 && cur_code < CP_MIN_4B) ||
                     cur_code > CP_MAX ||
                     (cur_code >= CP_SURR_LO && cur_code <= CP_SURR_HI);

   // Break rule against the stored class flags of the previous character.
   assign want_break = prev_nz_ff && !brackets_ff &&
                       (prev_cjk_ff || is_cjk(cur_code)) &&
                       !prev_gap_ff && !is_gap(cur_code) &&
                       !prev_open_ff && !is_close(cur_code);

   // Per-beat decision: fail, finish a character, or keep collecting.
   always_comb begin
      exp_len_in   = exp_len_ff;
      seen_len_in  = seen_len_ff;
      code_in      = code_ff;
      rune_in      = rune_ff;
      prev_nz_in   = prev_nz_ff;
      prev_cjk_in  = prev_cjk_ff;
      prev_gap_in  = prev_gap_ff;
      prev_open_in = prev_open_ff;
      brackets_in  = brackets_ff;
      discard_in   = discard_ff;
      do_fail      = 1'b0;
      do_finish    = 1'b0;
      push         = 1'b0;

      push_job.err     = 1'b0;
      push_job.brk     = want_break;
      push_job.len_m1  = 2'(cur_len - 3'd1);
      push_job.bytes   = char_bytes;
      push_job.str_end = req_string_end;

      if (accept) begin
         if (discard_ff) begin
            if (req_string_end) begin
               discard_in = 1'b0;
            end
         end else if (exp_len_ff == 3'd0) begin
            if (lead_len == 3'd0) begin
               do_fail = 1'b1;
            end else if (lead_len == 3'd1) begin
               do_finish = 1'b1;
            end else if (req_string_end) begin
               do_fail = 1'b1;
            end else begin
               exp_len_in  = lead_len;
               seen_len_in = 3'd1;
               code_in     = lead_code;
               rune_in     = char_bytes;
            end
         end else begin
            if (req_in_byte[7:6] != 2'b10) begin
               do_fail = 1'b1;
            end else if (seen_next == exp_len_ff) begin
               do_finish = 1'b1;
            end else if (req_string_end) begin
               do_fail = 1'b1;
            end else begin
               seen_len_in = seen_next;
               code_in     = cont_code;
               rune_in     = char_bytes;
            end
         end

         if (do_finish && bad_code) begin
            do_fail = 1'b1;
         end

         if (do_fail) begin
            push           = 1'b1;
            push_job.err   = 1'b1;
            push_job.brk   = 1'b0;
            push_job.len_m1 = 2'd0;
            exp_len_in     = 3'd0;
            seen_len_in    = 3'd0;
            code_in        = 21'd0;
            prev_nz_in     = 1'b0;
            prev_cjk_in    = 1'b0;
            prev_gap_in    = 1'b0;
            prev_open_in   = 1'b0;
            brackets_in    = 1'b0;
            discard_in     = !req_string_end;
         end else if (do_finish) begin
            push         = 1'b1;
            exp_len_in   = 3'd0;
            seen_len_in  = 3'd0;
            code_in      = 21'd0;
            prev_nz_in   = (cur_code != 21'd0);
            prev_cjk_in  = is_cjk(cur_code);
            prev_gap_in  = is_gap(cur_code);
            prev_open_in = is_open(cur_code);
            if (cur_code == CP_LENT_OPEN) begin
               brackets_in = 1'b1;
            end else if (cur_code == CP_LENT_SHUT) begin
               brackets_in = 1'b0;
            end
            if (req_string_end) begin
               prev_nz_in   = 1'b0;
               prev_cjk_in  = 1'b0;
               prev_gap_in  = 1'b0;
               prev_open_in = 1'b0;
               brackets_in  = 1'b0;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff   <= 3'd0;
         seen_len_ff  <= 3'd0;
         code_ff      <= 21'd0;
         prev_nz_ff   <= 1'b0;
         prev_cjk_ff  <= 1'b0;
         prev_gap_ff  <= 1'b0;
         prev_open_ff <= 1'b0;
         brackets_ff  <= 1'b0;
         discard_ff   <= 1'b0;
      end else begin
         exp_len_ff   <= exp_len_in;
         seen_len_ff  <= seen_len_in;
         code_ff      <= code_in;
         prev_nz_ff   <= prev_nz_in;
         prev_cjk_ff  <= prev_cjk_in;
         prev_gap_ff  <= prev_gap_in;
         prev_open_ff <= prev_open_in;
         brackets_ff  <= brackets_in;
         discard_ff   <= discard_in;
      end
   end

   // Collected character bytes need no reset.
   always_ff @(posedge clock) begin
      rune_ff <= rune_in;
   end

   // While a bad string is being swallowed no character can be open.
   assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (exp_len_ff == 3'd0 && seen_len_ff == 3'd0))
      else $error("front: character state open while discarding");

   // A partly collected character always has fewer bytes than it needs.
   assert property (@(posedge clock) disable iff (reset)
      (exp_len_ff != 3'd0) |-> (seen_len_ff != 3'd0 && seen_len_ff < exp_len_ff))
      else $error("front: collected count out of range");

endmodule

>>> hw/rtl/ucbi_queue.sv
module ucbi_queue
   import ucbi_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy bookkeeping with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage is written only at the tail.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue: occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue: pop from empty queue");

endmodule

>>> hw/rtl/ucbi_back.sv
module ucbi_back
   import ucbi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_error,
   output logic        rsp_item_last,
   output logic        rsp_string_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       error_ff, error_in;
   logic       item_last_ff, item_last_in;
   logic       string_last_ff, string_last_in;

   logic       load;
   logic [2:0] last_idx;
   logic       at_last;
   logic [2:0] char_pos;

   // Index of the final result of the head job.
   always_comb begin
      if (head_job.err) begin
         last_idx = 3'd0;
      end else if (head_job.brk) begin
         last_idx = 3'(head_job.len_m1) + 3'd3;
      end else begin
         last_idx = 3'(head_job.len_m1);
      end
   end

   assign load     = head_valid && (!valid_ff || rsp_ready);
   assign at_last  = (idx_ff == last_idx);
   assign pop      = load && at_last;
   assign char_pos = head_job.brk ? 3'(idx_ff - 3'd3) : idx_ff;

   // Next result beat: break bytes first, then the character itself.
   always_comb begin
      idx_in         = idx_ff;
      valid_in       = valid_ff;
      byte_in        = byte_ff;
      error_in       = error_ff;
      item_last_in   = item_last_ff;
      string_last_in = string_last_ff;
      if (load) begin
         valid_in       = 1'b1;
         error_in       = head_job.err;
         item_last_in   = at_last;
         string_last_in = at_last && head_job.str_end;
         idx_in         = at_last ? 3'd0 : 3'(idx_ff + 3'd1);
         if (head_job.err) begin
            byte_in = 8'd0;
         end else if (head_job.brk && idx_ff < 3'd3) begin
            case (idx_ff[1:0])
               2'd0:    byte_in = ZWSP_BYTE0;
               2'd1:    byte_in = ZWSP_BYTE1;
               default: byte_in = ZWSP_BYTE2;
            endcase
         end else begin
            byte_in = head_job.bytes[char_pos[1:0]];
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      error_ff       <= error_in;
      item_last_ff   <= item_last_in;
      string_last_ff <= string_last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_error       = error_ff;
   assign rsp_item_last   = item_last_ff;
   assign rsp_string_last = string_last_ff;

   // An error result stands alone and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |-> (item_last_ff && byte_ff == 8'd0))
      else $error("back: malformed error result");

   // The serializer index never runs past a seven-beat job.
   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= 3'd6)
      else $error("back: result index out of range");

endmodule

>>> hw/rtl/utf8_cjk_break_inserter.sv
// A byte that completes a character or fails is written into the job queue, and its first
// result then passes through the output register before it can be taken.
// Throughput: one input beat per cycle while the job queue has room; results leave at one per
// cycle while the receiver takes them; a character gives 1 to 7 bytes (3 break, up to 4 text).
// Reset (synchronous, active high) clears decoder state, the job queue and the output register.
module utf8_cjk_break_inserter
   import ucbi_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_error,
   output logic        rsp_item_last,
   output logic        rsp_string_last
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // Decoder and break decision.
   ucbi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   // Job queue between decoder and serializer.
   ucbi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Result serializer with output register.
   ucbi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error       (rsp_error),
      .rsp_item_last   (rsp_item_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   // One output beat of the break inserter.
   typedef struct packed {
      logic [7:0] data;
      logic       err;
      logic       item_last;
      logic       string_last;
   } text_beat_type;

   // Code points the break rule cares about.
   localparam logic [20:0] ZERO_WIDTH_SPACE = 21'h00200B;
   localparam logic [20:0] LENTICULAR_OPEN  = 21'h003010;
   localparam logic [20:0] LENTICULAR_SHUT  = 21'h003011;
   localparam logic [20:0] UNICODE_TOP      = 21'h10FFFF;
   localparam logic [20:0] SURROGATE_FIRST  = 21'h00D800;
   localparam logic [20:0] SURROGATE_LAST   = 21'h00DFFF;
   localparam int          HOLD_CYCLES      = 300;

   // Receiver behaviors.
   localparam int RX_ALWAYS  = 0;
   localparam int RX_PATTERN = 1;
   localparam int RX_LIGHT   = 2;
   localparam int RX_HEAVY   = 3;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_error;
   logic       rsp_item_last;
   logic       rsp_string_last;

   utf8_cjk_break_inserter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_string_end  (req_string_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error       (rsp_error),
      .rsp_item_last   (rsp_item_last),
      .rsp_string_last (rsp_string_last)
   );

   // Results owed by the block, oldest first.
   text_beat_type owed_results[$];
   int            mismatches = 0;

   // Decoder state kept by the testbench.
   logic [2:0]  dec_need = 3'd0;
   logic [2:0]  dec_have = 3'd0;
   logic [20:0] dec_code = 21'd0;
   logic [7:0]  dec_raw[4];
   logic [20:0] last_cp = 21'd0;
   logic        in_lenticular = 1'b0;
   logic        skip_string = 1'b0;

   // Traffic shaping.
   int          burst_left = 0;
   int          gap_max = 0;
   int          rx_mode = RX_ALWAYS;
   int          hold_trigger = 0;
   logic [7:0]  line_buf[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Character classes used by the break rule.
   function automatic logic han_like(input logic [20:0] c);
      return (c >= 21'h2E80 && c <= 21'hA4CF) || (c >= 21'hAC00 && c <= 21'hD7AF) ||
             (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'hFF00 && c <= 21'hFFEF) ||
             (c >= 21'h20000 && c <= 21'h3134F);
   endfunction

   function automatic logic spacing_cp(input logic [20:0] c);
      return c == 21'h20 || c == 21'h0A || c == 21'h0D || c == 21'h09 ||
             c == 21'hA0 || c == ZERO_WIDTH_SPACE;
   endfunction

   function automatic logic opens_run(input logic [20:0] c);
      return c == LENTICULAR_OPEN || c == 21'hFF08 || c == 21'h300C || c == 21'h300E ||
             c == 21'h300A || c == 21'h3008 || c == 21'h2018 || c == 21'h201C;
   endfunction

   function automatic logic closes_run(input logic [20:0] c);
      return c == LENTICULAR_SHUT || c == 21'hFF09 || c == 21'h300D || c == 21'h300F ||
             c == 21'h300B || c == 21'h3009 || c == 21'h2019 || c == 21'h201D ||
             c == 21'h3001 || c == 21'h3002 || c == 21'hFF0C || c == 21'hFF1A ||
             c == 21'hFF1B || c == 21'hFF01 || c == 21'hFF1F;
   endfunction

   // Queue a result at the tail of the owed list.
   task automatic owe_result(input text_beat_type r);
      owed_results.insert(owed_results.size(), r);
   endtask

   // Add one byte at the end of the string being built.
   task automatic add_byte(input logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   // A bad byte gives one error beat and drops the rest of the string.
   task automatic flag_error(input logic e);
      text_beat_type r;
      dec_need = 3'd0;
      dec_have = 3'd0;
      dec_code = 21'd0;
      last_cp = 21'd0;
      in_lenticular = 1'b0;
      skip_string = ~e;
      r.data = 8'h00;
      r.err = 1'b1;
      r.item_last = 1'b1;
      r.string_last = e;
      owe_result(r);
   endtask

   // A complete character: validate, maybe break, then pass its bytes on.
   task automatic emit_char(input logic [2:0] len, input logic e);
      logic [7:0]    outs[7];
      int            n;
      text_beat_type r;
      if ((len == 3'd2 && dec_code < 21'h80) || (len == 3'd3 && dec_code < 21'h800) ||
          (len == 3'd4 && dec_code < 21'h10000) || dec_code > UNICODE_TOP ||
          (dec_code >= SURROGATE_FIRST && dec_code <= SURROGATE_LAST)) begin
         flag_error(e);
         return;
      end
      n = 0;
      if (last_cp != 21'd0 && !in_lenticular && (han_like(last_cp) || han_like(dec_code)) &&
          !spacing_cp(last_cp) && !spacing_cp(dec_code) && !opens_run(last_cp) &&
          !closes_run(dec_code)) begin
         outs[0] = 8'hE2;
         outs[1] = 8'h80;
         outs[2] = 8'h8B;
         n = 3;
      end
      for (int i = 0; i < len; i++) begin
         outs[n] = dec_raw[i];
         n++;
      end
      for (int k = 0; k < n; k++) begin
         r.data = outs[k];
         r.err = 1'b0;
         r.item_last = (k == n - 1);
         r.string_last = (k == n - 1) && e;
         owe_result(r);
      end
      if (dec_code == LENTICULAR_OPEN)
         in_lenticular = 1'b1;
      else if (dec_code == LENTICULAR_SHUT)
         in_lenticular = 1'b0;
      last_cp = e ? 21'd0 : dec_code;
      if (e)
         in_lenticular = 1'b0;
      dec_need = 3'd0;
      dec_have = 3'd0;
      dec_code = 21'd0;
   endtask

   // Works out what one accepted input byte should produce.
   task automatic decode_and_break(input logic [7:0] b, input logic e);
      logic [2:0] len;
      logic [7:0] mask;
      if (skip_string) begin
         if (e)
            skip_string = 1'b0;
         return;
      end
      if (dec_need == 3'd0) begin
         if (b[7] == 1'b0) begin
            len = 3'd1;
            mask = 8'h7F;
         end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
            mask = 8'h1F;
         end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
            mask = 8'h0F;
         end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
            mask = 8'h07;
         end else begin
            flag_error(e);
            return;
         end
         dec_raw[0] = b;
         dec_code = {13'd0, b & mask};
         if (len == 3'd1) begin
            emit_char(len, e);
            return;
         end
         if (e) begin
            flag_error(e);
            return;
         end
         dec_need = len;
         dec_have = 3'd1;
         return;
      end
      if (b[7:6] != 2'b10 || dec_have >= 3'd4) begin
         flag_error(e);
         return;
      end
      dec_code = {dec_code[14:0], b[5:0]};
      dec_raw[dec_have[1:0]] = b;
      dec_have = dec_have + 3'd1;
      if (dec_have >= dec_need)
         emit_char(dec_need, e);
      else if (e)
         flag_error(e);
   endtask

   // Compare every accepted output beat with the oldest owed result.
   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            $error("unexpected beat: out_byte %h error %b", rsp_out_byte, rsp_error);
            mismatches++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %h, got %h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_error !== want.err) begin
               $error("error: expected %b, got %b", want.err, rsp_error);
               mismatches++;
            end
            if (rsp_item_last !== want.item_last) begin
               $error("item_last: expected %b, got %b", want.item_last, rsp_item_last);
               mismatches++;
            end
            if (rsp_string_last !== want.string_last) begin
               $error("string_last: expected %b, got %b", want.string_last,
                      rsp_string_last);
               mismatches++;
            end
         end
      end
   end

   // Receiver: a long hold when asked, otherwise the current stall style.
   int          hold_seen = 0;
   int          hold_left = 0;
   logic [12:0] rx_pattern = 13'b1011011100101;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_PATTERN: begin
               rsp_ready <= rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[12:1]};
            end
            RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_ready <= ($urandom_range(0, 2) == 0);
            default:  rsp_ready <= 1'b1;
         endcase
      end
   end

   // Offer one input beat, with bursts and gaps, and predict it once taken.
   task automatic send_beat(input logic [7:0] b, input logic e);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max > 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_string_end <= e;
      do @(posedge clock); while (!req_ready);
      decode_and_break(b, e);
   endtask

   // Send the assembled string, marking its final byte.
   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_beat(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // Stop offering and wait until every owed result has come out.
   task automatic wait_all_out();
      req_valid <= 1'b0;
      burst_left = 0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic append_cp(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({5'b11110, cp[20:18]});
         add_byte({2'b10, cp[17:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endtask

   function automatic logic [7:0] tail_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // Byte sequences, mostly malformed, of the kinds the decoder must reject.
   task automatic append_broken();
      case ($urandom_range(0, 5))
         0: add_byte(8'($urandom_range(0, 255)));
         1: add_byte(tail_byte());
         2: begin
            case ($urandom_range(0, 2))
               0: add_byte(8'hC0 | 8'($urandom_range(0, 1)));
               1: begin
                  add_byte(8'hE0);
                  add_byte(8'h80 | 8'($urandom_range(0, 31)));
               end
               default: begin
                  add_byte(8'hF0);
                  add_byte(8'h80 | 8'($urandom_range(0, 15)));
                  add_byte(tail_byte());
               end
            endcase
            add_byte(tail_byte());
         end
         3: begin
            add_byte(8'hED);
            add_byte(8'hA0 | 8'($urandom_range(0, 31)));
            add_byte(tail_byte());
         end
         4: begin
            if ($urandom_range(0, 1)) begin
               add_byte(8'hF4);
               add_byte(8'h90 | 8'($urandom_range(0, 47)));
            end else begin
               add_byte(8'($urandom_range(8'hF5, 8'hF7)));
               add_byte(tail_byte());
            end
            add_byte(tail_byte());
            add_byte(tail_byte());
         end
         default: begin
            // Cut-off character: the lead and one continuation only.
            add_byte($urandom_range(0, 1) ? 8'hE4 : 8'hF0);
            add_byte(8'h90 | 8'($urandom_range(0, 15)));
         end
      endcase
   endtask

   // Pick a code point, weighted toward the classes the break rule tests.
   function automatic logic [20:0] pick_code();
      logic [20:0] edges[27] = '{21'h2E7F, 21'h2E80, 21'hA4CF, 21'hA4D0, 21'hABFF,
         21'hAC00, 21'hD7AF, 21'hD7B0, 21'hF8FF, 21'hF900, 21'hFAFF, 21'hFB00,
         21'hFEFF, 21'hFF00, 21'hFFEF, 21'hFFF0, 21'h1FFFF, 21'h20000, 21'h3134F,
         21'h31350, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'h10000, UNICODE_TOP};
      logic [20:0] marks[23] = '{LENTICULAR_OPEN, 21'hFF08, 21'h300C, 21'h300E,
         21'h300A, 21'h3008, 21'h2018, 21'h201C, LENTICULAR_SHUT, 21'hFF09, 21'h300D,
         21'h300F, 21'h300B, 21'h3009, 21'h2019, 21'h201D, 21'h3001, 21'h3002,
         21'hFF0C, 21'hFF1A, 21'hFF1B, 21'hFF01, 21'hFF1F};
      logic [20:0] gaps[6] = '{21'h20, 21'h0A, 21'h0D, 21'h09, 21'hA0, ZERO_WIDTH_SPACE};
      logic [20:0] c;
      case ($urandom_range(0, 11))
         0: c = ($urandom_range(0, 7) == 0) ? 21'd0 : 21'($urandom_range(1, 127));
         1: c = gaps[$urandom_range(0, 5)];
         2: c = 21'($urandom_range(21'h80, 21'h7FF));
         3, 4: c = 21'($urandom_range(21'h4E00, 21'h9FFF));
         5: c = 21'($urandom_range(21'hAC00, 21'hD7AF));
         6: c = marks[$urandom_range(0, 22)];
         7: c = $urandom_range(0, 1) ? LENTICULAR_OPEN : LENTICULAR_SHUT;
         8: c = 21'($urandom_range(21'h10000, UNICODE_TOP));
         9: c = 21'($urandom_range(21'h20000, 21'h3134F));
         10: c = edges[$urandom_range(0, 26)];
         default: begin
            c = 21'($urandom_range(21'h800, 21'hFFFF));
            if (c >= SURROGATE_FIRST && c <= SURROGATE_LAST)
               c = c + 21'h800;
         end
      endcase
      return c;
   endfunction

   // Strings of random text, mostly well formed, some with bad sequences.
   task automatic send_random_text(input int target);
      int sent;
      int nchars;
      sent = 0;
      while (sent < target) begin
         nchars = $urandom_range(1, 8);
         for (int k = 0; k < nchars; k++) begin
            if ($urandom_range(0, 99) < 10)
               append_broken();
            else
               append_cp(pick_code());
         end
         sent += line_buf.size();
         send_line();
      end
   endtask

   // Hand-picked strings: break placement, the NUL rule and each error kind.
   task automatic test_directed();
      gap_max = 3;
      rx_mode = RX_PATTERN;
      // NUL then two CJK characters then ASCII: breaks before the second CJK one and the ASCII one.
      line_buf = '{8'h00, 8'hE4, 8'hB8, 8'hAD, 8'hE6, 8'h96, 8'h87, 8'h41};
      send_line();
      // Bad lead byte; the rest of the string is swallowed.
      line_buf = '{8'hFF, 8'h41, 8'h42};
      send_line();
      // Bad continuation byte.
      line_buf = '{8'hE4, 8'h41, 8'h7F};
      send_line();
      // Overlong two-byte form.
      line_buf = '{8'hC0, 8'h80};
      send_line();
      // Surrogate.
      line_buf = '{8'hED, 8'hA0, 8'h80};
      send_line();
      // Just above the top code point.
      line_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
      send_line();
      // String ends in the middle of a character.
      line_buf = '{8'hE4, 8'hB8};
      send_line();
      wait_all_out();
   endtask

   task automatic test_random_light_stall();
      gap_max = 6;
      rx_mode = RX_LIGHT;
      send_random_text(140);
      wait_all_out();
   endtask

   // No idling on either side.
   task automatic test_steady_flow();
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      send_random_text(50);
      wait_all_out();
   endtask

   // Receiver holds off while CJK text keeps coming, so the input stalls.
   task automatic test_backpressure();
      gap_max = 0;
      rx_mode = RX_PATTERN;
      hold_trigger++;
      for (int k = 0; k < 20; k++)
         append_cp(21'($urandom_range(21'h4E00, 21'h9FFF)));
      send_line();
      wait_all_out();
   endtask

   task automatic test_random_heavy_stall();
      gap_max = 2;
      rx_mode = RX_HEAVY;
      send_random_text(140);
      wait_all_out();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_light_stall();
      test_steady_flow();
      test_backpressure();
      test_random_heavy_stall();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ucbi_pkg.sv
hw/rtl/ucbi_front.sv
hw/rtl/ucbi_queue.sv
hw/rtl/ucbi_back.sv
hw/rtl/utf8_cjk_break_inserter.sv
tb/sv/tb.sv
